@@ sv/spv_pkg.sv @@
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types and microprogram of the scheduled piecewise-linear value unit.
// ----------------------------------------------------------------------------
package spv_pkg;

    // input item kinds, carried on s_axis_tuser
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RESET = 2'd1,
        ACT_STEP  = 2'd2
    } t_action;

    // datapath operations of one microprogram step
    typedef enum logic [3:0] {
        U_NOP,
        U_READ0,      // read slot 0, index <= 1
        U_LOAD,       // x1/y1 <= read data
        U_READI,      // read slot at index, x0/y0 <= x1/y1, index++
        U_DIFF,       // dx, den, |dy| and its sign
        U_MUL,        // product <= dx * |dy|
        U_DIV,        // start the divider
        U_FIN_Q,      // held <= y0 +/- quotient, emit
        U_FIN_Y1,     // held <= y1, emit
        U_FIN_RST,    // held <= y1, zero increment, emit
        U_FIN_EMPTY   // held kept, empty status, emit
    } t_uop;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_EMPTY,      // no points in use
        C_RESET,      // current item is a reset
        C_LT,         // time below x1
        C_NOMORE,     // scan finished
        C_GE,         // x1 at or below time
        C_DIVBUSY     // divider still running
    } t_cond;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step ST_READ0  = 4'd0;
    localparam t_step ST_FIRST  = 4'd1;
    localparam t_step ST_BELOW  = 4'd2;
    localparam t_step ST_SCAN   = 4'd3;
    localparam t_step ST_NEXT   = 4'd4;
    localparam t_step ST_TAKE   = 4'd5;
    localparam t_step ST_EVAL   = 4'd6;
    localparam t_step ST_MUL    = 4'd7;
    localparam t_step ST_DIV    = 4'd8;
    localparam t_step ST_WAIT   = 4'd9;
    localparam t_step ST_INTERP = 4'd10;
    localparam t_step ST_HOLD   = 4'd11;
    localparam t_step ST_RESET  = 4'd12;
    localparam t_step ST_EMPTY  = 4'd13;

    // control store
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        unique case (pc)
            ST_READ0:  w = '{U_READ0,     C_EMPTY,   ST_EMPTY};
            ST_FIRST:  w = '{U_LOAD,      C_RESET,   ST_RESET};
            ST_BELOW:  w = '{U_NOP,       C_LT,      ST_HOLD};
            ST_SCAN:   w = '{U_NOP,       C_NOMORE,  ST_EVAL};
            ST_NEXT:   w = '{U_READI,     C_NONE,    ST_READ0};
            ST_TAKE:   w = '{U_LOAD,      C_ALWAYS,  ST_SCAN};
            ST_EVAL:   w = '{U_DIFF,      C_GE,      ST_HOLD};
            ST_MUL:    w = '{U_MUL,       C_NONE,    ST_READ0};
            ST_DIV:    w = '{U_DIV,       C_NONE,    ST_READ0};
            ST_WAIT:   w = '{U_NOP,       C_DIVBUSY, ST_WAIT};
            ST_INTERP: w = '{U_FIN_Q,     C_NONE,    ST_READ0};
            ST_HOLD:   w = '{U_FIN_Y1,    C_NONE,    ST_READ0};
            ST_RESET:  w = '{U_FIN_RST,   C_NONE,    ST_READ0};
            ST_EMPTY:  w = '{U_FIN_EMPTY, C_NONE,    ST_READ0};
            default:   w = '{U_NOP,       C_ALWAYS,  ST_EMPTY};
        endcase
        return w;
    endfunction

endpackage

@@ sv/spv_div.sv @@
// ----------------------------------------------------------------------------
// spv_div
// Restoring divider, one quotient bit per cycle, 64/32 with 32-bit quotient.
// ----------------------------------------------------------------------------
module spv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,  // high half must be below the divisor
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_quo <= i_dividend[31:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 32 bits hold it
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

@@ sv/scheduled_piecewise_linear_value_unit.sv @@
// ----------------------------------------------------------------------------
// scheduled_piecewise_linear_value_unit
// Breakpoint table with linear interpolation of a held value over time.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                    | content
//  ---------+-----+------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser action, tdata point data
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser status, tdata value/incr
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | point_count
//
//  Write items give no result. Reset items run READ0, FIRST and RESET;
//  empty-schedule items run READ0 and EMPTY. An interpolating step item runs
//  the setup and finish steps, NEXT, TAKE and SCAN for each breakpoint
//  passed in the scan, and waits on the bit-serial divider.
//  Reset is synchronous; the table has no reset and no clearing pass.
//  A finished result sits in the output register; the sequencer stalls on
//  its last step only when that register is still full.
//
module scheduled_piecewise_linear_value_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] point_index, [35:4] point_time, [67:36] point_value,
    // [99:68] time_now, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]   s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] current_out, [64:32] increment, [71:65] zero
    output logic [71:0]  m_axis_tdata,
    // [0] status
    output logic         m_axis_tuser,
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [4:0]   i_cfg_data
);

    import spv_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = AW + 1;   // slot index that can also hold the count

    // breakpoint table
    logic [31:0] r_mem_t [MAX_POINTS];
    logic [31:0] r_mem_v [MAX_POINTS];
    logic [31:0] r_rd_t;
    logic [31:0] r_rd_v;

    // sequencer
    logic        r_run;
    t_step       r_upc;
    logic        r_is_reset;
    logic [4:0]  r_point_count;
    t_uword      uw;
    logic        cond_true;
    logic        is_fin;
    logic        out_free;
    logic        advance;

    // datapath
    logic signed [31:0] r_x;
    logic signed [31:0] r_x0;
    logic signed [31:0] r_y0;
    logic signed [31:0] r_x1;
    logic signed [31:0] r_y1;
    logic [IW-1:0]      r_idx;
    logic [31:0]        r_dx;
    logic [31:0]        r_den;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [31:0]        r_held;
    logic [IW-1:0]      n_used;
    logic [32:0]        dy;
    logic [32:0]        interp;
    logic [31:0]        n_held;
    logic [32:0]        n_inc;

    // output register
    logic        r_m_valid;
    logic [31:0] r_m_cur;
    logic [32:0] r_m_inc;
    logic        r_m_status;

    // divider
    logic        div_start;
    logic        div_busy;
    logic [31:0] div_q;

    // input handshake and item fields
    logic        in_fire;
    logic [3:0]  in_index;
    logic        mem_we;
    logic        rd_en;
    logic [AW-1:0] rd_addr;

    assign s_axis_tready = !r_run;
    assign o_cfg_ready   = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_index      = s_axis_tdata[3:0];
    assign mem_we        = in_fire && (s_axis_tuser == ACT_WRITE)
                           && (32'(in_index) < MAX_POINTS);

    // a count above the table depth acts as the depth
    assign n_used = (32'(r_point_count) > MAX_POINTS) ? IW'(MAX_POINTS)
                                                      : IW'(r_point_count);

    // ---------------- microprogram control ----------------
    assign uw       = ucode(r_upc);
    assign is_fin   = (uw.op == U_FIN_Q) || (uw.op == U_FIN_Y1) ||
                      (uw.op == U_FIN_RST) || (uw.op == U_FIN_EMPTY);
    assign out_free = !r_m_valid || m_axis_tready;
    assign advance  = r_run && (!is_fin || out_free);

    always_comb begin
        unique case (uw.cond)
            C_NONE:    cond_true = 1'b0;
            C_ALWAYS:  cond_true = 1'b1;
            C_EMPTY:   cond_true = (n_used == '0);
            C_RESET:   cond_true = r_is_reset;
            C_LT:      cond_true = (r_x < r_x1);
            C_NOMORE:  cond_true = !((r_idx < n_used) && (r_x1 < r_x));
            C_GE:      cond_true = (r_x1 <= r_x);
            C_DIVBUSY: cond_true = div_busy;
            default:   cond_true = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_upc <= ST_READ0;
        end else if (in_fire && (s_axis_tuser == ACT_RESET ||
                                 s_axis_tuser == ACT_STEP)) begin
            r_run <= 1'b1;
            r_upc <= ST_READ0;
        end else if (advance) begin
            if (is_fin) begin
                r_run <= 1'b0;
            end
            r_upc <= cond_true ? uw.target : r_upc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    // ---------------- breakpoint table ----------------
    assign rd_en   = r_run && ((uw.op == U_READ0) || (uw.op == U_READI));
    assign rd_addr = (uw.op == U_READ0) ? '0 : AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_t[AW'(in_index)] <= s_axis_tdata[35:4];
            r_mem_v[AW'(in_index)] <= s_axis_tdata[67:36];
        end
        if (rd_en) begin
            r_rd_t <= r_mem_t[rd_addr];
            r_rd_v <= r_mem_v[rd_addr];
        end
    end

    // ---------------- datapath ----------------
    assign dy = {r_y1[31], r_y1} - {r_y0[31], r_y0};

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_is_reset <= (s_axis_tuser == ACT_RESET);
            r_x        <= s_axis_tdata[99:68];
        end
        if (advance) begin
            case (uw.op)
                U_READ0: r_idx <= IW'(1);
                U_LOAD: begin
                    r_x1 <= r_rd_t;
                    r_y1 <= r_rd_v;
                end
                U_READI: begin
                    r_x0  <= r_x1;
                    r_y0  <= r_y1;
                    r_idx <= r_idx + IW'(1);
                end
                U_DIFF: begin
                    // x0 < x < x1 here, so both differences fit 32 bits
                    r_dx  <= r_x - r_x0;
                    r_den <= r_x1 - r_x0;
                    r_neg <= dy[32];
                    r_mag <= dy[32] ? 32'(-dy) : dy[31:0];
                end
                U_MUL:   r_prod <= 64'(r_dx) * 64'(r_mag);
                default: ;
            endcase
        end
    end

    assign div_start = advance && (uw.op == U_DIV);

    spv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // quotient lies between 0 and |dy|, so the sum fits 32 bits
    assign interp = r_neg ? ({r_y0[31], r_y0} - {1'b0, div_q})
                          : ({r_y0[31], r_y0} + {1'b0, div_q});

    always_comb begin
        case (uw.op)
            U_FIN_Q:   n_held = interp[31:0];
            U_FIN_Y1:  n_held = r_y1;
            U_FIN_RST: n_held = r_y1;
            default:   n_held = r_held;
        endcase
        if (uw.op == U_FIN_Q || uw.op == U_FIN_Y1) begin
            n_inc = {n_held[31], n_held} - {r_held[31], r_held};
        end else begin
            n_inc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (advance && is_fin) begin
                r_held    <= n_held;
                r_m_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_fin) begin
            r_m_cur    <= n_held;
            r_m_inc    <= n_inc;
            r_m_status <= (uw.op == U_FIN_EMPTY);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_inc, r_m_cur};
    assign m_axis_tuser  = r_m_status;

    // ---------------- assertions ----------------
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> !div_busy)
        else $error("divider running with sequencer idle");

    a_empty_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status) |-> (r_m_inc == '0))
        else $error("empty result with non-zero increment");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && uw.op == U_FIN_Q) |-> (div_q <= r_mag))
        else $error("quotient beyond value span");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_run))
        else $error("result appeared without a running item");

endmodule

@@ bench/tb_scheduled_piecewise_linear_value_unit.sv @@
// ----------------------------------------------------------------------------
// tb_scheduled_piecewise_linear_value_unit
// Self-checking bench for the breakpoint table and interpolating value unit.
// ----------------------------------------------------------------------------
// Items go in on the input stream and are mirrored into a behavioural copy of
// the schedule when they are accepted. Reset and step items queue the value,
// increment and status they should produce. A checker pops that queue for
// every result taken off the output stream. A directed part covers the empty
// schedule, a single point, extreme times and values, the time below the
// first point and the ignored action code. Random traffic then runs under
// several idle and stall patterns, with the point count changed only while the
// unit is idle.
// ----------------------------------------------------------------------------
module tb_scheduled_piecewise_linear_value_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spv_pkg::*;

    // action code that the unit drops without a result
    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;
    localparam int   SLOTS        = 16;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;

    // one result item as it should appear
    typedef struct packed {
        logic [31:0] cur;
        logic [32:0] incr;
        logic        status;
    } t_held_result;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [4:0]   i_cfg_data    = '0;

    // behavioural copy of the schedule
    logic signed [31:0] sched_time  [SLOTS];
    logic signed [31:0] sched_value [SLOTS];
    logic signed [31:0] held_value  = '0;
    logic [4:0]         cfg_points  = '0;

    t_held_result pending_values[$];
    int           fail_count     = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    scheduled_piecewise_linear_value_unit #(
        .MAX_POINTS (SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Walk the breakpoints forward while the upper point lies below the time,
    // then hold an end value or interpolate with a truncating divide.
    function automatic logic signed [31:0] interp_held_value(
        logic signed [31:0] tnow, int used);
        longint t_now, t_lo, v_lo, t_hi, v_hi, dv;
        longint unsigned span_t, span_run, mag, quot;
        int slot;
        t_now = tnow;
        t_lo  = 0;
        v_lo  = 0;
        t_hi  = sched_time[0];
        v_hi  = sched_value[0];
        slot  = 1;
        if (t_now < t_hi)
            return v_hi[31:0];
        while (slot < used && t_hi < t_now) begin
            t_lo = t_hi;
            v_lo = v_hi;
            t_hi = sched_time[slot];
            v_hi = sched_value[slot];
            slot++;
        end
        if (t_hi <= t_now)
            return v_hi[31:0];
        span_run = t_now - t_lo;
        span_t   = t_hi - t_lo;
        dv       = v_hi - v_lo;
        mag      = (dv < 0) ? -dv : dv;
        // product stays below 2^64, so an unsigned 64-bit divide is exact
        quot     = (span_run * mag) / span_t;
        if (dv < 0)
            return 32'(v_lo - longint'(quot));
        return 32'(v_lo + longint'(quot));
    endfunction

    // Apply one accepted item to the copy; queue a result where one is due.
    function automatic void advance_schedule(logic [1:0] act, logic [3:0] idx,
        logic signed [31:0] ptime, logic signed [31:0] pval,
        logic signed [31:0] tnow);
        int                 used;
        logic signed [31:0] prev_value;
        t_held_result       res;
        used = (cfg_points > SLOTS) ? SLOTS : int'(cfg_points);
        if (act == ACT_WRITE) begin
            sched_time[idx]  = ptime;
            sched_value[idx] = pval;
            return;
        end
        if (act == ACT_IGNORED)
            return;
        prev_value = held_value;
        res.status = STATUS_OK;
        if (used == 0) begin
            res.status = STATUS_EMPTY;
        end else if (act == ACT_RESET) begin
            held_value = sched_value[0];
            prev_value = held_value;
        end else begin
            held_value = interp_held_value(tnow, used);
        end
        res.cur  = held_value;
        res.incr = 33'(longint'(held_value) - longint'(prev_value));
        pending_values.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one item, wait for acceptance, then maybe leave a gap.
    // tvalid is only lowered when a gap follows, so back-to-back items keep it
    // high without a second assignment in the same step.
    task automatic send_item(logic [1:0] act, logic [3:0] idx, logic [31:0] ptime,
        logic [31:0] pval, logic [31:0] tnow);
        int gap;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, tnow, pval, ptime, idx};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_schedule(act, idx, ptime, pval, tnow);
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input stream until every queued result has come, then let
    // in-flight writes settle.
    task automatic drain_results(int settle);
        s_axis_tvalid <= 1'b0;
        for (int c = 0; c < 200000 && pending_values.size() != 0; c++)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // point count is only changed with the unit idle
    task automatic write_point_count(logic [4:0] cnt);
        drain_results(8);
        i_cfg_data  <= cnt;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_points = cnt;
        i_cfg_valid <= 1'b0;
    endtask

    // receiver back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_held_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                $error("result item with none expected: current_out %0d",
                       $signed(m_axis_tdata[31:0]));
                fail_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_axis_tdata[31:0] !== want.cur) begin
                    $error("current_out: expected %0d, got %0d",
                           $signed(want.cur), $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[64:32] !== want.incr) begin
                    $error("increment: expected %0d, got %0d",
                           $signed(want.incr), $signed(m_axis_tdata[64:32]));
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(7))
            0:       return Q16_MIN;
            1:       return Q16_MAX;
            2, 3, 4: return $urandom();
            default: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    // step times mostly land on, beside or between breakpoints
    function automatic logic [31:0] pick_step_time();
        int     k;
        longint t_lo, t_hi, t_pick;
        k    = $urandom_range(SLOTS - 2);
        t_lo = sched_time[k];
        t_hi = sched_time[k + 1];
        case ($urandom_range(9))
            0:       return Q16_MIN;
            1:       return Q16_MAX;
            2, 3:    return $urandom();
            4, 5, 6: t_pick = t_lo + longint'($urandom_range(6)) - 3;
            default: begin
                if (t_hi > t_lo)
                    t_pick = t_lo + ((t_hi - t_lo) * longint'($urandom_range(1000))) / 1000;
                else
                    t_pick = t_hi;
            end
        endcase
        if (t_pick > longint'(Q16_MAX)) t_pick = Q16_MAX;
        if (t_pick < longint'(Q16_MIN)) t_pick = Q16_MIN;
        return t_pick[31:0];
    endfunction

    function automatic logic [4:0] pick_count();
        case ($urandom_range(7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd2;
            3:       return 5'd16;
            4:       return 5'd17;
            5:       return 5'd31;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    // Load all slots with ascending times, strict below the time maximum, spread wide or clustered.
    task automatic fill_schedule();
        longint pts [SLOTS];
        longint base, tmp;
        int     span_log, j, k;
        base     = longint'($signed($urandom()));
        span_log = $urandom_range(4, 28);
        for (k = 0; k < SLOTS; k++) begin
            if (span_log > 26)
                pts[k] = longint'($signed($urandom()));
            else
                pts[k] = base + longint'($urandom_range(32'd1 << span_log));
            if (pts[k] > longint'(Q16_MAX)) pts[k] = Q16_MAX;
        end
        for (j = 1; j < SLOTS; j++) begin
            tmp = pts[j];
            k   = j;
            while (k > 0 && pts[k - 1] > tmp) begin
                pts[k] = pts[k - 1];
                k--;
            end
            pts[k] = tmp;
        end
        for (k = 1; k < SLOTS; k++)
            if (pts[k] <= pts[k - 1] && pts[k - 1] < longint'(Q16_MAX))
                pts[k] = pts[k - 1] + 1;
        for (k = 0; k < SLOTS; k++)
            send_item(ACT_WRITE, k[3:0], pts[k][31:0], rand_q16(), $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // no points in use: status empty, value held, increment zero
    task automatic test_empty_schedule();
        write_point_count(5'd0);
        send_item(ACT_RESET, 4'd0, $urandom(), $urandom(), $urandom());
        send_item(ACT_STEP, 4'd15, $urandom(), $urandom(), Q16_MAX);
    endtask

    // action code 3 is dropped with no result
    task automatic test_ignored_action();
        send_item(ACT_IGNORED, 4'd5, Q16_MAX, Q16_MIN, Q16_MIN);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // slots 0..3 span the whole time axis with full-scale value swings
    task automatic test_load_extremes();
        send_item(ACT_WRITE, 4'd0, Q16_MIN, Q16_MAX, 32'd0);
        send_item(ACT_WRITE, 4'd1, 32'd0, Q16_MIN, 32'd0);
        send_item(ACT_WRITE, 4'd2, 32'h0001_0000, 32'd0, 32'd0);
        send_item(ACT_WRITE, 4'd3, Q16_MAX, Q16_MAX, 32'd0);
        send_item(ACT_WRITE, 4'd15, Q16_MAX, Q16_MIN, Q16_MAX);
    endtask

    // one point: every time gives its value
    task automatic test_single_point();
        write_point_count(5'd1);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, Q16_MIN);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, Q16_MAX);
        send_item(ACT_RESET, 4'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // full-scale increments both ways, exact hits and wide interpolation
    task automatic test_interpolation_extremes();
        write_point_count(5'd4);
        send_item(ACT_RESET, 4'd0, 32'd0, 32'd0, 32'd0);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, 32'd0);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, Q16_MAX);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, Q16_MIN);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, 32'h0000_8000);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, 32'h0001_0001);
    endtask

    // first point moved above the time axis minimum
    task automatic test_below_first_point();
        send_item(ACT_WRITE, 4'd0, -32'sd100, 32'sd12345, 32'd0);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, Q16_MIN);
        send_item(ACT_STEP, 4'd0, 32'd0, 32'd0, -32'sd100);
    endtask

    // Mostly well-formed schedules probed around their breakpoints, with
    // stray writes that can break the ordering, resets and dropped items.
    task automatic run_random_items(int n_items, int send_pct, int recv_pct);
        int done, next_cfg_at, pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        done        = 0;
        next_cfg_at = 0;
        while (done < n_items) begin
            if (done >= next_cfg_at) begin
                write_point_count(pick_count());
                next_cfg_at += 75;
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                fill_schedule();
                done += SLOTS;
            end else if (pick < 11) begin
                send_item(ACT_WRITE, 4'($urandom_range(15)), $urandom(), rand_q16(),
                          $urandom());
                done++;
            end else if (pick < 18) begin
                send_item(ACT_RESET, 4'($urandom_range(15)), $urandom(), $urandom(),
                          $urandom());
                done++;
            end else if (pick < 21) begin
                send_item(ACT_IGNORED, 4'($urandom_range(15)), $urandom(), $urandom(),
                          $urandom());
            end else begin
                send_item(ACT_STEP, 4'($urandom_range(15)), $urandom(), $urandom(),
                          pick_step_time());
                done++;
            end
        end
    endtask

    task automatic test_random_traffic();
        fill_schedule();
        write_point_count(5'd16);
        run_random_items(300, 0, 0);
        run_random_items(300, 47, 0);
        run_random_items(300, 0, 47);
        run_random_items(300, 29, 29);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_schedule();
        test_ignored_action();
        test_load_extremes();
        test_single_point();
        test_interpolation_extremes();
        test_below_first_point();
        test_random_traffic();

        drain_results(100);
        if (pending_values.size() != 0) begin
            $error("%0d result items never arrived", pending_values.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
